[hdl/mts_pkg.sv]
// shared constants, types and state codes of the motion trajectory smoother
// no dependencies; imported by every module in hdl

package mts_pkg;

    localparam int HISTORY_DEPTH = 64;
    localparam int DATA_W        = 32;
    localparam int PTR_W         = $clog2(HISTORY_DEPTH);
    localparam int CNT_W         = $clog2(HISTORY_DEPTH + 1);
    // trajectory point: sum of up to HISTORY_DEPTH estimates
    localparam int TRAJ_W        = DATA_W + PTR_W + 1;
    // window sum: sum of up to HISTORY_DEPTH trajectory points
    localparam int SUM_W         = TRAJ_W + PTR_W + 1;
    // correction: estimate + average - trajectory point
    localparam int CORR_W        = SUM_W + 2;
    localparam int QCNT_W        = $clog2(SUM_W + 1);

    localparam int MF_W          = 7;
    localparam int RAD_W         = 6;
    localparam int CFG_IDX_W     = 1;
    localparam int CFG_DATA_W    = 7;

    localparam logic [MF_W-1:0]  MAX_FRAMES_RST = 7'd60;
    localparam logic [RAD_W-1:0] RADIUS_RST     = 6'd50;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_FRAMES = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS     = 1'd1;

    typedef logic signed [DATA_W-1:0] t_data;
    typedef logic signed [TRAJ_W-1:0] t_traj;
    typedef logic signed [SUM_W-1:0]  t_sum;
    typedef t_data [2:0] t_data3;
    typedef t_traj [2:0] t_traj3;
    typedef t_sum  [2:0] t_sum3;

    typedef struct packed {
        logic push;
        logic clear;
    } t_hist_ctrl;

    typedef struct packed {
        logic             done;
        logic [CNT_W-1:0] count;
        logic [CNT_W-1:0] held;
    } t_hist_stat;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_HIST,
        ST_DIV,
        ST_CORR,
        ST_EMIT
    } t_state;

endpackage

[hdl/motion_trajectory_smoother.sv]
// top level of the motion trajectory smoother: config registers, sequencer
// and output register; depends on mts_pkg, mts_history, mts_serial_div,
// mts_correct
//
// usage
//   input channel: one transfer per video frame; i_func low pushes a motion
//   estimate (x shift, y shift, rotation), i_func high clears the history
//   output channel: one result per push, none per clear; corrected shifts
//   and rotation for the newest frame plus the number of estimates held
//   config channel: always ready; index 0 max_frames, index 1 window
//   radius; write only while the block is idle
//   latency: a push takes about frames_held + 55 cycles from its transfer to
//   o_out_valid (about 119 with 64 estimates held); the history pass reads
//   one entry per cycle from the ring memory, and the divider then spends
//   one cycle per bit of the window sum
//   throughput: one push at a time; a clear takes one cycle
//   o_in_ready is high whenever the sequencer is idle, also while a result
//   waits in the output register
//   receiver stall: the result holds in the output register; a following
//   push is worked on and waits at its last step until the register frees
//   reset: synchronous active low; history empty, registers back to
//   max_frames 60 and window radius 50, no result pending

module motion_trajectory_smoother
    import mts_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,

    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  logic                   i_func,
    input  logic signed [31:0]     i_delta_x,
    input  logic signed [31:0]     i_delta_y,
    input  logic signed [31:0]     i_delta_angle,

    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic signed [31:0]     o_corrected_x,
    output logic signed [31:0]     o_corrected_y,
    output logic signed [31:0]     o_corrected_angle,
    output logic [6:0]             o_frames_held,

    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    t_state             r_state;
    t_state             n_state;

    logic [MF_W-1:0]    r_max_frames;
    logic [RAD_W-1:0]   r_radius;
    t_data3             r_delta;

    logic               r_out_valid;
    t_data3             r_out_corr;
    logic [6:0]         r_out_held;

    t_hist_ctrl         w_hist_ctrl;
    t_hist_stat         w_hist_stat;
    t_traj3             w_run;
    t_sum3              w_win;
    logic               w_div_start;
    logic               w_div_done;
    t_sum3              w_quot;
    logic               w_corr_start;
    logic               w_corr_done;
    t_data3             w_corr;
    logic               w_in_xfer;
    logic               w_load;
    t_data3             w_delta_in;

    assign w_in_xfer     = i_in_valid && o_in_ready;
    assign w_delta_in[0] = i_delta_x;
    assign w_delta_in[1] = i_delta_y;
    assign w_delta_in[2] = i_delta_angle;

    // sequencer state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and step strobes
    always_comb begin
        n_state           = r_state;
        o_in_ready        = 1'b0;
        w_hist_ctrl.push  = 1'b0;
        w_hist_ctrl.clear = 1'b0;
        w_div_start       = 1'b0;
        w_corr_start      = 1'b0;
        w_load            = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (i_func) begin
                        // clear: history empties, no result
                        w_hist_ctrl.clear = 1'b1;
                    end else begin
                        w_hist_ctrl.push = 1'b1;
                        n_state          = ST_HIST;
                    end
                end
            end
            ST_HIST: begin
                if (w_hist_stat.done) begin
                    w_div_start = 1'b1;
                    n_state     = ST_DIV;
                end
            end
            ST_DIV: begin
                if (w_div_done) begin
                    w_corr_start = 1'b1;
                    n_state      = ST_CORR;
                end
            end
            ST_CORR: begin
                if (w_corr_done) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                // wait for the output register to be free
                if (!r_out_valid || i_out_ready) begin
                    w_load  = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // config registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_frames <= MAX_FRAMES_RST;
            r_radius     <= RADIUS_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_MAX_FRAMES: r_max_frames <= MF_W'(i_cfg_data);
                CFG_RADIUS:     r_radius     <= i_cfg_data[RAD_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // newest estimate, held for the correction step
    always_ff @(posedge i_clk) begin
        if (w_in_xfer && !i_func) begin
            r_delta <= w_delta_in;
        end
    end

    mts_history u_history (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctrl       (w_hist_ctrl),
        .i_delta      (w_delta_in),
        .i_max_frames (r_max_frames),
        .i_radius     (r_radius),
        .o_stat       (w_hist_stat),
        .o_run        (w_run),
        .o_win        (w_win)
    );

    mts_serial_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_win),
        .i_den   (w_hist_stat.count),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    mts_correct u_correct (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_corr_start),
        .i_quot  (w_quot),
        .i_run   (w_run),
        .i_delta (r_delta),
        .o_done  (w_corr_done),
        .o_corr  (w_corr)
    );

    // output register, parts the result from the next push
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_corr <= w_corr;
            r_out_held <= 7'(w_hist_stat.held);
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_corrected_x     = r_out_corr[0];
    assign o_corrected_y     = r_out_corr[1];
    assign o_corrected_angle = r_out_corr[2];
    assign o_frames_held     = r_out_held;

endmodule

[hdl/mts_history.sv]
// estimate history ring and trajectory pass: streams the held estimates
// oldest first, one entry per cycle, building the trajectory and window sums
// depends on mts_pkg

module mts_history
    import mts_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_hist_ctrl        i_ctrl,
    input  t_data3            i_delta,
    input  logic [MF_W-1:0]   i_max_frames,
    input  logic [RAD_W-1:0]  i_radius,
    output t_hist_stat        o_stat,
    output t_traj3            o_run,
    output t_sum3             o_win
);

    localparam int LW = (CNT_W > MF_W) ? CNT_W : MF_W;

    t_data3             mem [HISTORY_DEPTH];
    t_data3             r_rd_data;

    logic [CNT_W-1:0]   r_held;
    logic [PTR_W-1:0]   r_wp;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_issue_left;
    logic [CNT_W-1:0]   r_count;
    logic               r_busy;
    logic               r_s1_valid;
    logic               r_s1_win;
    logic               r_s2_valid;
    logic               r_s2_win;
    t_traj3             r_run;
    t_sum3              r_win;

    logic [LW-1:0]      w_mf;
    logic [LW-1:0]      w_lim;
    logic [LW-1:0]      w_held;
    logic [LW-1:0]      w_base;
    logic [LW-1:0]      w_new;
    logic [LW-1:0]      w_want;
    logic [LW-1:0]      w_cnt;
    logic [PTR_W:0]     w_wp_ext;
    logic [PTR_W:0]     w_base_ext;
    logic [PTR_W:0]     w_oldest;
    logic [PTR_W-1:0]   w_wp_next;
    logic [PTR_W-1:0]   w_rd_next;
    logic               w_issue;
    logic               w_done;

    always_comb begin
        w_mf = LW'(i_max_frames);
        if (w_mf == '0) begin
            w_lim = LW'(1);
        end else if (w_mf > LW'(HISTORY_DEPTH)) begin
            w_lim = LW'(HISTORY_DEPTH);
        end else begin
            w_lim = w_mf;
        end
        // a full history drops down to one below the limit before the push
        w_held = LW'(r_held);
        w_base = (w_held >= w_lim) ? (w_lim - LW'(1)) : w_held;
        w_new  = w_base + LW'(1);
        w_want = LW'(i_radius) + LW'(1);
        w_cnt  = (w_want < w_new) ? w_want : w_new;

        w_wp_ext   = (PTR_W+1)'(r_wp);
        w_base_ext = (PTR_W+1)'(w_base);
        if (w_wp_ext >= w_base_ext) begin
            w_oldest = w_wp_ext - w_base_ext;
        end else begin
            w_oldest = w_wp_ext + (PTR_W+1)'(HISTORY_DEPTH) - w_base_ext;
        end

        w_wp_next = (r_wp == PTR_W'(HISTORY_DEPTH - 1)) ? '0 : r_wp + PTR_W'(1);
        w_rd_next = (r_rd_ptr == PTR_W'(HISTORY_DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);

        w_issue = r_busy && (r_issue_left != '0);
        w_done  = r_busy && !w_issue && !r_s1_valid && !r_s2_valid;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.push) begin
            mem[r_wp] <= i_delta;
        end
        if (w_issue) begin
            r_rd_data <= mem[r_rd_ptr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held       <= '0;
            r_wp         <= '0;
            r_rd_ptr     <= '0;
            r_issue_left <= '0;
            r_count      <= '0;
            r_busy       <= 1'b0;
            r_s1_valid   <= 1'b0;
            r_s1_win     <= 1'b0;
            r_s2_valid   <= 1'b0;
            r_s2_win     <= 1'b0;
        end else begin
            if (i_ctrl.clear) begin
                r_held <= '0;
                r_wp   <= '0;
            end else if (i_ctrl.push) begin
                r_held       <= CNT_W'(w_new);
                r_wp         <= w_wp_next;
                r_rd_ptr     <= PTR_W'(w_oldest);
                r_issue_left <= CNT_W'(w_new);
                r_count      <= CNT_W'(w_cnt);
                r_busy       <= 1'b1;
            end else begin
                if (w_issue) begin
                    r_rd_ptr     <= w_rd_next;
                    r_issue_left <= r_issue_left - CNT_W'(1);
                end
                if (w_done) begin
                    r_busy <= 1'b0;
                end
            end
            // the newest r_count entries fall inside the averaging window
            r_s1_valid <= w_issue;
            r_s1_win   <= w_issue && (r_issue_left <= r_count);
            r_s2_valid <= r_s1_valid;
            r_s2_win   <= r_s1_win;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.push) begin
            r_run <= '0;
            r_win <= '0;
        end else begin
            for (int i = 0; i < 3; i++) begin
                if (r_s1_valid) begin
                    r_run[i] <= r_run[i] + TRAJ_W'($signed(r_rd_data[i]));
                end
                if (r_s2_valid && r_s2_win) begin
                    r_win[i] <= r_win[i] + SUM_W'($signed(r_run[i]));
                end
            end
        end
    end

    assign o_stat.done  = w_done;
    assign o_stat.count = r_count;
    assign o_stat.held  = r_held;
    assign o_run        = r_run;
    assign o_win        = r_win;

endmodule

[hdl/mts_serial_div.sv]
// three-lane bit-serial restoring divider, one quotient bit per cycle,
// quotient truncated toward zero
// depends on mts_pkg

module mts_serial_div
    import mts_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  t_sum3            i_num,
    input  logic [CNT_W-1:0] i_den,
    output logic             o_done,
    output t_sum3            o_quot
);

    logic                         r_busy;
    logic                         r_fix;
    logic                         r_done;
    logic [QCNT_W-1:0]            r_bits;
    logic [CNT_W-1:0]             r_den;
    logic [2:0]                   r_neg;
    logic [2:0][SUM_W-1:0]        r_dvd;
    logic [2:0][CNT_W-1:0]        r_rem;
    t_sum3                        r_quot;

    logic [2:0][CNT_W:0]          w_trial;
    logic [2:0]                   w_ge;
    logic [2:0][CNT_W-1:0]        w_rem_next;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_trial[i] = {r_rem[i], r_dvd[i][SUM_W-1]};
            w_ge[i]    = (w_trial[i] >= {1'b0, r_den});
            if (w_ge[i]) begin
                w_rem_next[i] = CNT_W'(w_trial[i] - {1'b0, r_den});
            end else begin
                w_rem_next[i] = CNT_W'(w_trial[i]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fix  <= 1'b0;
            r_done <= 1'b0;
            r_bits <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_bits <= QCNT_W'(SUM_W);
            end else if (r_busy) begin
                r_bits <= r_bits - QCNT_W'(1);
                if (r_bits == QCNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_fix  <= 1'b1;
                end
            end else if (r_fix) begin
                r_fix  <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            if (i_start) begin
                r_neg[i] <= i_num[i][SUM_W-1];
                r_dvd[i] <= i_num[i][SUM_W-1] ? SUM_W'(-i_num[i]) : SUM_W'(i_num[i]);
                r_rem[i] <= '0;
            end else if (r_busy) begin
                // quotient bits shift in where dividend bits leave
                r_dvd[i] <= {r_dvd[i][SUM_W-2:0], w_ge[i]};
                r_rem[i] <= w_rem_next[i];
            end else if (r_fix) begin
                r_quot[i] <= r_neg[i] ? -$signed(r_dvd[i]) : $signed(r_dvd[i]);
            end
        end
        if (i_start) begin
            r_den <= i_den;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

[hdl/mts_correct.sv]
// two-stage correction: average minus trajectory point, plus the estimate,
// saturated to 32 bits signed
// depends on mts_pkg

module mts_correct
    import mts_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_start,
    input  t_sum3  i_quot,
    input  t_traj3 i_run,
    input  t_data3 i_delta,
    output logic   o_done,
    output t_data3 o_corr
);

    logic                              r_v1;
    logic                              r_done;
    logic signed [2:0][CORR_W-1:0]     r_diff;
    t_data3                            r_res;

    logic signed [2:0][CORR_W-1:0]     w_sum;
    logic [2:0][CORR_W-DATA_W:0]       w_hi;
    t_data3                            w_sat;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_sum[i] = $signed(r_diff[i]) + CORR_W'($signed(i_delta[i]));
            w_hi[i]  = w_sum[i][CORR_W-1:DATA_W-1];
            if ((&w_hi[i]) || !(|w_hi[i])) begin
                w_sat[i] = w_sum[i][DATA_W-1:0];
            end else if (w_sum[i][CORR_W-1]) begin
                w_sat[i] = {1'b1, {(DATA_W-1){1'b0}}};
            end else begin
                w_sat[i] = {1'b0, {(DATA_W-1){1'b1}}};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1   <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_v1   <= i_start;
            r_done <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            if (i_start) begin
                r_diff[i] <= CORR_W'($signed(i_quot[i])) - CORR_W'($signed(i_run[i]));
            end
            if (r_v1) begin
                r_res[i] <= w_sat[i];
            end
        end
    end

    assign o_done = r_done;
    assign o_corr = r_res;

endmodule

[hdl/mts_checker.sv]
// port-level checks of the motion trajectory smoother, bound to the top level
// depends on mts_pkg and motion_trajectory_smoother

module mts_port_assert
    import mts_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_in_valid,
    input logic                   o_in_ready,
    input logic                   i_func,
    input logic                   o_out_valid,
    input logic                   i_out_ready,
    input logic signed [31:0]     o_corrected_x,
    input logic signed [31:0]     o_corrected_y,
    input logic signed [31:0]     o_corrected_angle,
    input logic [6:0]             o_frames_held
);

    // no result right after reset
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    // a push keeps the block busy in the following cycle
    a_push_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && !i_func) |=> !o_in_ready)
        else $error("input ready right after a push transfer");

    // a result never reports an empty or overfull history
    a_held_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_frames_held != 7'd0)
                        && (int'(o_frames_held) <= HISTORY_DEPTH))
        else $error("frames_held out of range");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> o_out_valid && $stable(o_corrected_x)
            && $stable(o_corrected_y) && $stable(o_corrected_angle)
            && $stable(o_frames_held))
        else $error("stalled result changed");

endmodule

bind motion_trajectory_smoother mts_port_assert u_mts_port_assert (.*);
